### rtl/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared widths and types for the quadratic root solver pipeline.
// ----------------------------------------------------------------------------
package qrs_pkg;

    localparam int COEF_W    = 32;
    localparam int DISC_W    = 68;   // b*b + 4|ac| stays below 2^67
    localparam int ROOT_W    = 34;   // floor sqrt of the discriminant
    localparam int SQREM_W   = 37;
    localparam int SQ_STAGES = 17;   // two root bits per stage
    localparam int FRONT_ST  = 3;
    localparam int NUM_W     = 35;   // magnitude of -b +/- sqrt(D)
    localparam int DIVS_W    = 33;   // 2|a|
    localparam int DVREM_W   = 34;

    typedef struct packed {
        logic                has;
        logic                aneg;
        logic [COEF_W-1:0]   amag;
        logic                bneg;
        logic [COEF_W-1:0]   bmag;
    } qrs_side_t;

    typedef struct packed {
        logic [DISC_W-1:0]   disc;
        qrs_side_t           side;
    } qrs_front_t;

endpackage

### rtl/qrs_if.sv
// ----------------------------------------------------------------------------
// qrs_in_if / qrs_out_if
// Valid/ready channels for coefficient items and root items.
// ----------------------------------------------------------------------------
interface qrs_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic signed [31:0] coef_c;

    modport source (output valid, coef_a, coef_b, coef_c, input ready);
    modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] root_plus;
    logic signed [31:0] root_minus;
    logic               has_roots;
    logic               saturated;

    modport source (output valid, root_plus, root_minus, has_roots, saturated, input ready);
    modport sink   (input valid, root_plus, root_minus, has_roots, saturated, output ready);
endinterface

### rtl/qrs_front.sv
// ----------------------------------------------------------------------------
// qrs_front
// Magnitudes, the two 32x32 products and the discriminant, three stages.
// ----------------------------------------------------------------------------
module qrs_front
    import qrs_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [COEF_W-1:0] coef_a,
    input  logic signed [COEF_W-1:0] coef_b,
    input  logic signed [COEF_W-1:0] coef_c,
    output qrs_front_t               dout
);

    logic [COEF_W-1:0]   am_reg, bm_reg, cm_reg;
    logic                an_reg, bn_reg, cn_reg;
    logic [2*COEF_W-1:0] bb_reg, ac_reg;
    logic [COEF_W-1:0]   am2_reg, bm2_reg;
    logic                an2_reg, bn2_reg, opp_reg;
    qrs_front_t          out_reg;
    qrs_front_t          out_next;
    logic [2*COEF_W+1:0] m4;
    logic [2*COEF_W+1:0] bbx;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            an_reg  <= coef_a[COEF_W-1];
            bn_reg  <= coef_b[COEF_W-1];
            cn_reg  <= coef_c[COEF_W-1];
            am_reg  <= coef_a[COEF_W-1] ? (~coef_a + 1'b1) : coef_a;
            bm_reg  <= coef_b[COEF_W-1] ? (~coef_b + 1'b1) : coef_b;
            cm_reg  <= coef_c[COEF_W-1] ? (~coef_c + 1'b1) : coef_c;
            bb_reg  <= bm_reg * bm_reg;
            ac_reg  <= am_reg * cm_reg;
            am2_reg <= am_reg;
            bm2_reg <= bm_reg;
            an2_reg <= an_reg;
            bn2_reg <= bn_reg;
            opp_reg <= an_reg ^ cn_reg;
            out_reg <= out_next;
        end
    end

    always_comb
    begin
        m4  = {ac_reg, 2'b00};
        bbx = {2'b00, bb_reg};
        out_next.side.aneg = an2_reg;
        out_next.side.amag = am2_reg;
        out_next.side.bneg = bn2_reg;
        out_next.side.bmag = bm2_reg;
        if (opp_reg)
        begin
            // a*c negative: discriminant grows
            out_next.disc     = DISC_W'(bbx) + DISC_W'(m4);
            out_next.side.has = |am2_reg;
        end
        else
        begin
            out_next.disc     = DISC_W'(bbx - m4);
            out_next.side.has = (|am2_reg) && (m4 <= bbx);
        end
    end

    assign dout = out_reg;

endmodule

### rtl/qrs_sqrt.sv
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined digit-by-digit floor square root, two root bits per stage.
// ----------------------------------------------------------------------------
module qrs_sqrt
    import qrs_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  qrs_front_t        din,
    output logic [ROOT_W-1:0] root,
    output qrs_side_t         side
);

    logic [SQREM_W-1:0] rem_reg  [SQ_STAGES];
    logic [ROOT_W-1:0]  root_reg [SQ_STAGES];
    logic [DISC_W-1:0]  d_reg    [SQ_STAGES];
    qrs_side_t          side_reg [SQ_STAGES];

    for (genvar s = 0; s < SQ_STAGES; s++)
    begin : g_st
        logic [SQREM_W-1:0] r_in, r_next;
        logic [ROOT_W-1:0]  q_in, q_next;
        logic [DISC_W-1:0]  d_in, d_next;
        qrs_side_t          sd_in;
        logic [SQREM_W-1:0] trial;

        if (s == 0)
        begin : g_src0
            assign r_in  = '0;
            assign q_in  = '0;
            assign d_in  = din.disc;
            assign sd_in = din.side;
        end
        else
        begin : g_srcn
            assign r_in  = rem_reg[s-1];
            assign q_in  = root_reg[s-1];
            assign d_in  = d_reg[s-1];
            assign sd_in = side_reg[s-1];
        end

        always_comb
        begin
            r_next = r_in;
            q_next = q_in;
            d_next = d_in;
            trial  = '0;
            for (int i = 0; i < 2; i++)
            begin
                r_next = {r_next[SQREM_W-3:0], d_next[DISC_W-1:DISC_W-2]};
                d_next = {d_next[DISC_W-3:0], 2'b00};
                trial  = {1'b0, q_next, 2'b01};
                if (r_next >= trial)
                begin
                    r_next = r_next - trial;
                    q_next = {q_next[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    q_next = {q_next[ROOT_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= r_next;
                root_reg[s] <= q_next;
                d_reg[s]    <= d_next;
                side_reg[s] <= sd_in;
            end
        end
    end

    assign root = root_reg[SQ_STAGES-1];
    assign side = side_reg[SQ_STAGES-1];

endmodule

### rtl/qrs_div.sv
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined restoring divider, two quotient bits per stage, with clamp to
// the signed 32-bit range on the way out.
// ----------------------------------------------------------------------------
module qrs_div
    import qrs_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               en,
    input  logic [NUM_W-1:0]   nmag,
    input  logic               neg,
    input  logic [DIVS_W-1:0]  dmag,
    output logic [COEF_W-1:0]  quo,
    output logic               sat
);

    localparam int NW = ((NUM_W + FRAC_BITS + 1) / 2) * 2;
    localparam int ST = NW / 2;

    logic [DVREM_W-1:0] rem_reg  [ST];
    logic [NW-1:0]      work_reg [ST];
    logic [DIVS_W-1:0]  dv_reg   [ST];
    logic               neg_reg  [ST];
    logic [COEF_W-1:0]  quo_reg, quo_next;
    logic               sat_reg, sat_next;

    for (genvar s = 0; s < ST; s++)
    begin : g_st
        logic [DVREM_W-1:0] r_in, r_next;
        logic [NW-1:0]      w_in, w_next;
        logic [DIVS_W-1:0]  d_in;
        logic               n_in;

        if (s == 0)
        begin : g_src0
            assign r_in = '0;
            assign w_in = NW'(nmag) << FRAC_BITS;
            assign d_in = dmag;
            assign n_in = neg;
        end
        else
        begin : g_srcn
            assign r_in = rem_reg[s-1];
            assign w_in = work_reg[s-1];
            assign d_in = dv_reg[s-1];
            assign n_in = neg_reg[s-1];
        end

        always_comb
        begin
            r_next = r_in;
            w_next = w_in;
            for (int i = 0; i < 2; i++)
            begin
                r_next = {r_next[DVREM_W-2:0], w_next[NW-1]};
                w_next = {w_next[NW-2:0], 1'b0};
                if (r_next >= {1'b0, d_in})
                begin
                    r_next    = r_next - {1'b0, d_in};
                    w_next[0] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= r_next;
                work_reg[s] <= w_next;
                dv_reg[s]   <= d_in;
                neg_reg[s]  <= n_in;
            end
        end
    end

    always_comb
    begin
        logic [NW-1:0] q;
        logic          hi_nz;
        q     = work_reg[ST-1];
        hi_nz = |q[NW-1:COEF_W];
        if (neg_reg[ST-1])
        begin
            sat_next = hi_nz || (q[COEF_W-1] && (|q[COEF_W-2:0]));
            quo_next = sat_next ? {1'b1, {(COEF_W-1){1'b0}}} : (~q[COEF_W-1:0] + 1'b1);
        end
        else
        begin
            sat_next = hi_nz || q[COEF_W-1];
            quo_next = sat_next ? {1'b0, {(COEF_W-1){1'b1}}} : q[COEF_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= quo_next;
            sat_reg <= sat_next;
        end
    end

    assign quo = quo_reg;
    assign sat = sat_reg;

endmodule

### rtl/quadratic_root_solver_core.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver_core
// Real roots of a*x^2 + b*x + c in signed fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// Accepts one coefficient item per clock while the pipeline is not held and
// returns one root item per item in order, through three front stages for
// magnitudes, products and the discriminant, 17 square-root stages, one
// numerator stage, the divider stages and one clamp stage. The whole
// pipeline holds while the output item waits, so throughput is one item per
// cycle whenever the sink takes it.
module quadratic_root_solver_core
    import qrs_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    qrs_in_if.sink    operands,
    qrs_out_if.source roots
);

    localparam int DIV_ST = ((NUM_W + FRAC_BITS + 1) / 2) * 2 / 2;
    localparam int LAT    = FRONT_ST + SQ_STAGES + 1 + DIV_ST + 1;
    localparam logic [COEF_W-1:0] MINUS_ONE = COEF_W'(-(64'sd1 <<< FRAC_BITS));

    logic              en;
    logic [LAT-1:0]    vld_reg;
    logic [DIV_ST+1:0] has_reg;
    qrs_front_t        front;
    logic [ROOT_W-1:0] sroot;
    qrs_side_t         side;
    logic [NUM_W-1:0]  pmag_reg, mmag_reg;
    logic              pneg_reg, mneg_reg;
    logic [DIVS_W-1:0] dv_reg;
    logic [NUM_W:0]    negb, np, nm;
    logic [COEF_W-1:0] qp, qm;
    logic              sp, sm;

    assign en             = !vld_reg[LAT-1] || roots.ready;
    assign operands.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], operands.valid};
        end
    end

    qrs_front u_front (
        .clk    (clk),
        .en     (en),
        .coef_a (operands.coef_a),
        .coef_b (operands.coef_b),
        .coef_c (operands.coef_c),
        .dout   (front)
    );

    qrs_sqrt u_sqrt (
        .clk  (clk),
        .en   (en),
        .din  (front),
        .root (sroot),
        .side (side)
    );

    // -b +/- sqrt(D) as sign and magnitude
    always_comb
    begin
        negb = side.bneg ? {4'b0, side.bmag} : (~{4'b0, side.bmag} + 1'b1);
        np   = negb + {2'b00, sroot};
        nm   = negb - {2'b00, sroot};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pneg_reg <= np[NUM_W] ^ side.aneg;
            mneg_reg <= nm[NUM_W] ^ side.aneg;
            pmag_reg <= np[NUM_W] ? NUM_W'(~np + 1'b1) : np[NUM_W-1:0];
            mmag_reg <= nm[NUM_W] ? NUM_W'(~nm + 1'b1) : nm[NUM_W-1:0];
            dv_reg   <= {side.amag, 1'b0};
            has_reg  <= {has_reg[DIV_ST:0], side.has};
        end
    end

    qrs_div #(.FRAC_BITS(FRAC_BITS)) u_div_plus (
        .clk  (clk),
        .en   (en),
        .nmag (pmag_reg),
        .neg  (pneg_reg),
        .dmag (dv_reg),
        .quo  (qp),
        .sat  (sp)
    );

    qrs_div #(.FRAC_BITS(FRAC_BITS)) u_div_minus (
        .clk  (clk),
        .en   (en),
        .nmag (mmag_reg),
        .neg  (mneg_reg),
        .dmag (dv_reg),
        .quo  (qm),
        .sat  (sm)
    );

    assign roots.valid      = vld_reg[LAT-1];
    assign roots.has_roots  = has_reg[DIV_ST+1];
    assign roots.root_plus  = has_reg[DIV_ST+1] ? qp : MINUS_ONE;
    assign roots.root_minus = has_reg[DIV_ST+1] ? qm : MINUS_ONE;
    assign roots.saturated  = has_reg[DIV_ST+1] && (sp || sm);

endmodule

### rtl/qrs_checker.sv
// ----------------------------------------------------------------------------
// qrs_checker
// Port-level checks for the quadratic root solver, bound to the top level.
// ----------------------------------------------------------------------------
module qrs_checker
#(
    parameter int FRAC_BITS = 16
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] root_plus,
    input logic [31:0] root_minus,
    input logic        has_roots,
    input logic        saturated
);

    localparam logic [31:0] MINUS_ONE = 32'(-(64'sd1 <<< FRAC_BITS));

    // no-roots items carry the sentinel and never a clamp
    a_no_roots: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !has_roots) |->
        (root_plus == MINUS_ONE && root_minus == MINUS_ONE && !saturated))
        else $error("no-roots item without sentinel");

    // input side stalls only while the output item is held
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input stalled without output back-pressure");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
        (out_valid && $stable(root_plus) && $stable(root_minus)
         && $stable(has_roots) && $stable(saturated)))
        else $error("output item changed while stalled");

    // a stalled input side never accepts
    a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("item accepted during stall");

endmodule

bind quadratic_root_solver_core qrs_checker #(.FRAC_BITS(FRAC_BITS)) u_qrs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (operands.valid),
    .in_ready   (operands.ready),
    .out_valid  (roots.valid),
    .out_ready  (roots.ready),
    .root_plus  (roots.root_plus),
    .root_minus (roots.root_minus),
    .has_roots  (roots.has_roots),
    .saturated  (roots.saturated)
);
